// ===== src/dlpd_pkg.sv =====
// Package of constants and types for the decimal length-prefixed deframer.
package dlpd_pkg;

  // Sizing
  localparam int LENGTH_LINE_MAX     = 10;
  localparam int PAYLOAD_BUFFER_SIZE = 4096;
  localparam int CNT_W   = $clog2(LENGTH_LINE_MAX + 1);
  localparam int PC_W    = $clog2(PAYLOAD_BUFFER_SIZE);
  localparam int MAG_W   = 30;
  localparam int IDLE_W  = 17;
  localparam int TMO_W   = 16;
  localparam int LEN_W   = 31;

  localparam logic [MAG_W-1:0]  MAG_LIMIT   = MAG_W'(999999999);
  localparam logic [IDLE_W-1:0] IDLE_MAX    = {IDLE_W{1'b1}};
  localparam logic [TMO_W-1:0]  TIMEOUT_RST = TMO_W'(300);

  // Input item function codes
  localparam logic [1:0] FUNC_DATA  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_STOP  = 2'd2;
  localparam logic [1:0] FUNC_TICK  = 2'd3;

  // Parser phase codes
  localparam logic [1:0] PH_LENGTH   = 2'd0;
  localparam logic [1:0] PH_PAYLOAD  = 2'd1;
  localparam logic [1:0] PH_FINISHED = 2'd2;
  localparam logic [1:0] PH_ERROR    = 2'd3;

  // Number scan codes
  localparam logic [1:0] SCAN_SKIP = 2'd0;
  localparam logic [1:0] SCAN_NUM  = 2'd1;
  localparam logic [1:0] SCAN_DONE = 2'd2;

  // Characters
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [1:0]       phase;
    logic [CNT_W-1:0] char_cnt;
    logic [1:0]       scan;
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic [PC_W-1:0]  pay_cnt;
    logic             active;
  } parse_t;

  localparam parse_t PARSE_CLEAR = '{
    phase:    PH_LENGTH,
    char_cnt: '0,
    scan:     SCAN_SKIP,
    neg:      1'b0,
    mag:      '0,
    pay_cnt:  '0,
    active:   1'b0
  };

endpackage

// ===== src/decimal_length_prefixed_deframer.sv =====
// Decimal length-prefixed deframer: top level with parser, session timer and result register.
// The result of an accepted input transaction is registered and shows in the cycle after it.
// Throughput: one transaction per cycle; the input stalls only while a held result is stalled.
// Reset (rst_n low, synchronous): parser to the length phase, session inactive, idle
// count zero, timeout register back to 300 seconds, result register empty.
module decimal_length_prefixed_deframer (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_func,
  input  logic [7:0]                     in_data_byte,
  // Result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_status,
  output logic                           out_payload_valid,
  output logic [7:0]                     out_payload_byte,
  output logic [dlpd_pkg::PC_W-1:0]      out_payload_index,
  output logic                           out_finished,
  output logic                           out_clear_cache,
  output logic                           out_active,
  output logic signed [dlpd_pkg::LEN_W-1:0] out_declared_length,
  // Configuration channel: idle timeout in seconds
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dlpd_pkg::TMO_W-1:0]     cfg_data
);
  import dlpd_pkg::*;

  // Parser and session state
  parse_t              ps_r, ps_nxt;
  logic [IDLE_W-1:0]   idle_r, idle_nxt;
  logic [TMO_W-1:0]    timeout_r;

  // Result register
  logic                out_valid_r, out_valid_nxt;
  logic                status_r, status_nxt;
  logic                pvalid_r, pvalid_nxt;
  logic [7:0]          pbyte_r, pbyte_nxt;
  logic [PC_W-1:0]     pidx_r, pidx_nxt;
  logic                finished_r;
  logic                clear_r, clear_nxt;
  logic                active_r;
  logic [LEN_W-1:0]    dlen_r, dlen_nxt;

  logic                in_accept;
  logic                is_digit;
  logic                is_blank;
  logic [MAG_W+3:0]    mag_x10;
  logic [PC_W:0]       pay_n;

  // The result register frees up when it is empty or its transaction completes this cycle
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Character classes of the incoming byte
  assign is_digit = (in_data_byte >= CH_ZERO) && (in_data_byte <= CH_NINE);
  assign is_blank = (in_data_byte == CH_SPACE) ||
                    ((in_data_byte >= CH_TAB) && (in_data_byte <= CH_CR));

  // Magnitude times ten plus the new digit, as shift-and-add
  assign mag_x10 = {1'b0, ps_r.mag, 3'b000} + {3'b000, ps_r.mag, 1'b0}
                 + (MAG_W+4)'(in_data_byte[3:0]);

  // Payload count after this byte
  assign pay_n = {1'b0, ps_r.pay_cnt} + (PC_W+1)'(1);

  // Next-state and result logic for one transaction
  always_comb begin
    ps_nxt     = ps_r;
    idle_nxt   = idle_r;
    status_nxt = 1'b0;
    pvalid_nxt = 1'b0;
    pbyte_nxt  = '0;
    pidx_nxt   = '0;
    clear_nxt  = 1'b0;

    unique case (in_func)
      FUNC_START: begin
        ps_nxt        = PARSE_CLEAR;
        ps_nxt.active = 1'b1;
        idle_nxt      = '0;
      end
      FUNC_STOP: begin
        ps_nxt.active = 1'b0;
        idle_nxt      = '0;
      end
      FUNC_TICK: begin
        // Count idle seconds, saturate at the top
        if (idle_r != IDLE_MAX) begin
          idle_nxt = idle_r + IDLE_W'(1);
        end
      end
      FUNC_DATA: begin
        if (ps_r.phase == PH_ERROR) begin
          // Report the bad reply and start over; the idle count stays
          ps_nxt     = PARSE_CLEAR;
          status_nxt = 1'b1;
        end else begin
          if (ps_r.phase == PH_LENGTH) begin
            if (ps_r.char_cnt == CNT_W'(LENGTH_LINE_MAX)) begin
              // Length line too long
              ps_nxt       = PARSE_CLEAR;
              ps_nxt.phase = PH_ERROR;
            end else begin
              ps_nxt.char_cnt = ps_r.char_cnt + CNT_W'(1);
              if (in_data_byte != CH_LF) begin
                // atoi-style scan: whitespace, sign, digits, then stop
                if (ps_r.scan == SCAN_SKIP) begin
                  if (!is_blank) begin
                    if (in_data_byte == CH_PLUS || in_data_byte == CH_MINUS) begin
                      ps_nxt.neg  = (in_data_byte == CH_MINUS);
                      ps_nxt.scan = SCAN_NUM;
                    end else if (is_digit) begin
                      ps_nxt.mag  = MAG_W'(in_data_byte[3:0]);
                      ps_nxt.scan = SCAN_NUM;
                    end else begin
                      ps_nxt.scan = SCAN_DONE;
                    end
                  end
                end else if (ps_r.scan == SCAN_NUM) begin
                  if (is_digit) begin
                    ps_nxt.mag = (mag_x10 > (MAG_W+4)'(MAG_LIMIT)) ?
                                 MAG_LIMIT : mag_x10[MAG_W-1:0];
                  end else begin
                    ps_nxt.scan = SCAN_DONE;
                  end
                end
              end else if (ps_r.neg || ps_r.mag == '0) begin
                // Zero or negative length
                ps_nxt       = PARSE_CLEAR;
                ps_nxt.phase = PH_ERROR;
              end else begin
                ps_nxt.phase = PH_PAYLOAD;
              end
            end
          end

          // The line feed that closes the length line is payload byte zero
          if (ps_nxt.phase == PH_PAYLOAD) begin
            if (pay_n >= (PC_W+1)'(PAYLOAD_BUFFER_SIZE)) begin
              // Buffer full: drop the frame without a report
              ps_nxt = PARSE_CLEAR;
            end else begin
              ps_nxt.pay_cnt = pay_n[PC_W-1:0];
              pvalid_nxt     = 1'b1;
              pbyte_nxt      = in_data_byte;
              pidx_nxt       = ps_r.pay_cnt;
              if (MAG_W'(pay_n) > ps_r.mag) begin
                ps_nxt.active = 1'b0;
                ps_nxt.phase  = PH_FINISHED;
              end
            end
          end

          if (ps_nxt.phase == PH_FINISHED) begin
            clear_nxt     = 1'b1;
            ps_nxt.active = 1'b0;
          end
          idle_nxt = '0;
        end
      end
      default: begin
        ps_nxt = ps_r;
      end
    endcase

    // Idle timeout drops the session
    if (idle_nxt > {1'b0, timeout_r}) begin
      ps_nxt.active = 1'b0;
    end

    dlen_nxt = ps_nxt.neg ? (LEN_W'(0) - {1'b0, ps_nxt.mag}) : {1'b0, ps_nxt.mag};
  end

  // Result register: load on accept, empty when the held transaction completes
  always_comb begin
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r        <= PARSE_CLEAR;
      idle_r      <= '0;
      timeout_r   <= TIMEOUT_RST;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        ps_r   <= ps_nxt;
        idle_r <= idle_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        timeout_r <= cfg_data;
      end
    end
  end

  // Result payload: no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      status_r   <= status_nxt;
      pvalid_r   <= pvalid_nxt;
      pbyte_r    <= pbyte_nxt;
      pidx_r     <= pidx_nxt;
      finished_r <= (ps_nxt.phase == PH_FINISHED);
      clear_r    <= clear_nxt;
      active_r   <= ps_nxt.active;
      dlen_r     <= dlen_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_payload_valid   = pvalid_r;
  assign out_payload_byte    = pbyte_r;
  assign out_payload_index   = pidx_r;
  assign out_finished        = finished_r;
  assign out_clear_cache     = clear_r;
  assign out_active          = active_r;
  assign out_declared_length = signed'(dlen_r);

  // An error report never carries a payload byte
  a_status_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r |-> !pvalid_r)
    else $error("error report carries a payload byte");

  // A cache-clear pulse only comes with the finished phase, with the session down
  a_clear_finished: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && clear_r |-> finished_r && !active_r)
    else $error("cache clear outside the finished phase");

  // Every way into the error phase passes through a parser clear
  a_error_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    ps_r.phase == PH_ERROR |-> ps_r.mag == '0 && !ps_r.neg && ps_r.pay_cnt == '0)
    else $error("error phase holds parse state");

  // Payload bytes have been counted only in the payload or finished phase
  a_paycnt_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ps_r.pay_cnt != '0 |-> ps_r.phase == PH_PAYLOAD || ps_r.phase == PH_FINISHED)
    else $error("payload count outside the payload phase");

  // A held, stalled result blocks the input
  a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r)
    else $error("stalled result lost");

endmodule

// ===== sim/tb_decimal_length_prefixed_deframer.sv =====
// Self-checking testbench for the decimal length-prefixed deframer.
module tb_decimal_length_prefixed_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  import dlpd_pkg::*;

  // One result transaction as the block presents it, field by field.
  typedef struct packed {
    logic        status;
    logic        pay_valid;
    logic [7:0]  pay_byte;
    logic [11:0] pay_index;
    logic        finished;
    logic        clear_cache;
    logic        active;
    logic [30:0] length;
  } deframe_result_t;

  // One row of the opening stimulus; known rows carry a hand-written result.
  typedef struct packed {
    logic [1:0]      func;
    logic [7:0]      data;
    logic            known;
    deframe_result_t want;
  } stim_row_t;

  localparam int OPENING_ROWS = 25;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_func = FUNC_DATA;
  logic [7:0]        in_data_byte = 8'h00;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_status;
  logic              out_payload_valid;
  logic [7:0]        out_payload_byte;
  logic [PC_W-1:0]   out_payload_index;
  logic              out_finished;
  logic              out_clear_cache;
  logic              out_active;
  logic signed [LEN_W-1:0] out_declared_length;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [TMO_W-1:0]  cfg_data = '0;

  // Predicted parser, session and register state of the block.
  logic [1:0]        p_phase = PH_LENGTH;
  logic [CNT_W-1:0]  p_chars = '0;
  logic [1:0]        p_scan = SCAN_SKIP;
  logic              p_neg = 1'b0;
  logic [MAG_W-1:0]  p_mag = '0;
  logic [12:0]       p_count = '0;
  logic              p_active = 1'b0;
  logic [IDLE_W-1:0] p_idle = '0;
  logic [TMO_W-1:0]  p_timeout = TIMEOUT_RST;

  deframe_result_t pending_results[$];
  deframe_result_t oldest;
  stim_row_t       opening_rows[OPENING_ROWS];
  int unsigned     mismatches = 0;
  int unsigned     items_sent = 0;
  int unsigned     stall_left = 0;
  bit              allow_idle = 1'b1;
  bit              idle_on = 1'b1;

  decimal_length_prefixed_deframer u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_func             (in_func),
    .in_data_byte        (in_data_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_payload_valid   (out_payload_valid),
    .out_payload_byte    (out_payload_byte),
    .out_payload_index   (out_payload_index),
    .out_finished        (out_finished),
    .out_clear_cache     (out_clear_cache),
    .out_active          (out_active),
    .out_declared_length (out_declared_length),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Parser reset: drop the number being scanned, the payload count and the session.
  function automatic void clear_parse();
    p_phase  = PH_LENGTH;
    p_chars  = '0;
    p_scan   = SCAN_SKIP;
    p_neg    = 1'b0;
    p_mag    = '0;
    p_count  = '0;
    p_active = 1'b0;
  endfunction

  // Advance the predicted state by one input transaction and return its result.
  function automatic deframe_result_t deframe_step(input logic [1:0] f, input logic [7:0] b);
    deframe_result_t r;
    logic [12:0]     n;
    logic [63:0]     wide;
    logic            is_digit;
    logic            is_blank;
    r        = '0;
    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    is_blank = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    case (f)
      FUNC_START: begin
        clear_parse();
        p_active = 1'b1;
        p_idle   = '0;
      end
      FUNC_STOP: begin
        p_active = 1'b0;
        p_idle   = '0;
      end
      FUNC_TICK: begin
        if (p_idle != IDLE_MAX) p_idle = p_idle + IDLE_W'(1);
      end
      FUNC_DATA: begin
        if (p_phase == PH_ERROR) begin
          // A byte after an error reports it and rearms the parser; idle count holds.
          clear_parse();
          r.status = 1'b1;
        end else begin
          if (p_phase == PH_LENGTH) begin
            if (p_chars == CNT_W'(LENGTH_LINE_MAX)) begin
              // Length line too long: the line feed would not fit.
              clear_parse();
              p_phase = PH_ERROR;
            end else begin
              p_chars = p_chars + CNT_W'(1);
              if (b != CH_LF) begin
                // atoi-style scan: blanks, then one sign, then digits until a non-digit
                if (p_scan == SCAN_SKIP) begin
                  if (!is_blank) begin
                    if (b == CH_PLUS || b == CH_MINUS) begin
                      p_neg  = (b == CH_MINUS);
                      p_scan = SCAN_NUM;
                    end else if (is_digit) begin
                      p_mag  = MAG_W'(b - CH_ZERO);
                      p_scan = SCAN_NUM;
                    end else begin
                      p_scan = SCAN_DONE;
                    end
                  end
                end else if (p_scan == SCAN_NUM) begin
                  if (is_digit) begin
                    wide  = 64'(p_mag) * 64'd10 + 64'(b - CH_ZERO);
                    p_mag = (wide > 64'(MAG_LIMIT)) ? MAG_LIMIT : MAG_W'(wide);
                  end else begin
                    p_scan = SCAN_DONE;
                  end
                end
              end else if (p_neg || p_mag == '0) begin
                // Zero, negative or missing length
                clear_parse();
                p_phase = PH_ERROR;
              end else begin
                p_phase = PH_PAYLOAD;
              end
            end
          end
          if (p_phase == PH_PAYLOAD) begin
            n = p_count + 13'd1;
            if (n >= 13'(PAYLOAD_BUFFER_SIZE)) begin
              // Buffer full: restart quietly, the byte is lost
              clear_parse();
            end else begin
              p_count     = n;
              r.pay_valid = 1'b1;
              r.pay_byte  = b;
              r.pay_index = 12'(n - 13'd1);
              if (30'(n) > p_mag) begin
                p_active = 1'b0;
                p_phase  = PH_FINISHED;
              end
            end
          end
          if (p_phase == PH_FINISHED) begin
            r.clear_cache = 1'b1;
            p_active      = 1'b0;
          end
          p_idle = '0;
        end
      end
    endcase
    if (17'(p_idle) > 17'(p_timeout)) p_active = 1'b0;
    r.finished = (p_phase == PH_FINISHED);
    r.active   = p_active;
    r.length   = p_neg ? (31'd0 - {1'b0, p_mag}) : {1'b0, p_mag};
    return r;
  endfunction

  function automatic deframe_result_t outcome(input logic st, input logic pv,
                                              input logic [7:0] pb, input logic [11:0] pi,
                                              input logic fin, input logic clr,
                                              input logic act, input logic [30:0] len);
    deframe_result_t r;
    r = '{st, pv, pb, pi, fin, clr, act, len};
    return r;
  endfunction

  // Drive one input transaction, maybe after a short gap, and hold it until accepted.
  // Returns at the accepting edge so the next call can drive without a gap.
  task automatic push_item(input logic [1:0] f, input logic [7:0] b,
                           input logic known, input deframe_result_t want);
    deframe_result_t computed;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= f;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
    computed = deframe_step(f, b);
    pending_results.push_back(known ? want : computed);
  endtask

  // Send a decimal number, most significant digit first, behind some leading zeros.
  task automatic send_number(input int unsigned val, input int unsigned zeros);
    int unsigned div;
    repeat (zeros) push_item(FUNC_DATA, CH_ZERO, 1'b0, '0);
    div = 1;
    while (div * 10 <= val) div = div * 10;
    while (div != 0) begin
      push_item(FUNC_DATA, CH_ZERO + 8'((val / div) % 10), 1'b0, '0);
      div = div / 10;
    end
  endtask

  // Drain every outstanding result, settle, then write the idle timeout.
  task automatic retune(input logic [TMO_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    p_timeout = value;
  endtask

  // One random frame: mostly well-formed length lines and payloads, some broken, some noise.
  task automatic send_frame();
    int unsigned shape;
    int unsigned k;
    int unsigned len;
    int unsigned zeros;
    int unsigned cnt;
    shape   = $urandom_range(0, 99);
    idle_on = allow_idle && ($urandom_range(0, 4) != 0);
    if (shape < 10) begin
      // Raw noise: any operation, any byte
      repeat ($urandom_range(1, 6))
        push_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b0, '0);
      return;
    end
    if ($urandom_range(0, 9) != 0) push_item(FUNC_START, 8'($urandom_range(0, 255)), 1'b0, '0);
    // Leading blanks, never a line feed since that would end the line
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        k = $urandom_range(0, 4);
        push_item(FUNC_DATA, (k == 0) ? CH_TAB : (k == 4) ? CH_SPACE : CH_LF + 8'(k),
                  1'b0, '0);
      end
    end
    k = $urandom_range(0, 19);
    if (k < 2) push_item(FUNC_DATA, CH_MINUS, 1'b0, '0);
    else if (k < 5) push_item(FUNC_DATA, CH_PLUS, 1'b0, '0);
    k = $urandom_range(0, 19);
    if (k == 0) len = 0;
    else if (k == 1) len = $urandom_range(1000, 999999999);
    else len = $urandom_range(1, 12);
    zeros = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 8) : 0;
    send_number(len, zeros);
    // Trailing junk after the digits ends the number early
    if ($urandom_range(0, 9) == 0) push_item(FUNC_DATA, 8'($urandom_range(0, 255)), 1'b0, '0);
    push_item(FUNC_DATA, CH_LF, 1'b0, '0);
    cnt = (len <= 12) ? len : $urandom_range(0, 20);
    if ($urandom_range(0, 3) == 0) cnt = cnt + $urandom_range(0, 2);
    if (cnt > 0 && $urandom_range(0, 9) == 0) cnt = $urandom_range(0, cnt - 1);
    repeat (cnt) begin
      k = $urandom_range(0, 39);
      if (k == 0) push_item(FUNC_STOP, 8'($urandom_range(0, 255)), 1'b0, '0);
      else if (k < 3) push_item(FUNC_TICK, 8'($urandom_range(0, 255)), 1'b0, '0);
      push_item(FUNC_DATA, 8'($urandom_range(0, 255)), 1'b0, '0);
    end
    // Idle seconds between frames, enough to trip short timeouts
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 6)) push_item(FUNC_TICK, 8'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned target;
    target = items_sent + count;
    while (items_sent < target) send_frame();
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Receiver back-pressure: random stall bursts while idling is allowed.
  always @(posedge clk) begin
    if (stall_left != 0) stall_left = stall_left - 1;
    else if (idle_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 5);
    out_stall <= (stall_left != 0);
  end

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result with nothing expected, status %0h index %0h",
                 $time, out_status, out_payload_index);
        mismatches++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("status", oldest.status, out_status);
        check_field("payload_valid", oldest.pay_valid, out_payload_valid);
        check_field("payload_byte", oldest.pay_byte, out_payload_byte);
        check_field("payload_index", oldest.pay_index, out_payload_index);
        check_field("finished", oldest.finished, out_finished);
        check_field("clear_cache", oldest.clear_cache, out_clear_cache);
        check_field("active", oldest.active, out_active);
        check_field("declared_length", {1'b0, oldest.length}, {1'b0, out_declared_length});
      end
    end
  end

  initial begin
    int i;
    // Opening rows: error paths first, then a saturating over-long line, then a short frame.
    opening_rows[0]  = '{FUNC_DATA,  CH_LF,    1'b1, outcome(0, 0, 0, 0, 0, 0, 0, 0)};
    opening_rows[1]  = '{FUNC_DATA,  8'hFF,    1'b1, outcome(1, 0, 0, 0, 0, 0, 0, 0)};
    opening_rows[2]  = '{FUNC_START, 8'h00,    1'b1, outcome(0, 0, 0, 0, 0, 0, 1, 0)};
    opening_rows[3]  = '{FUNC_DATA,  CH_MINUS, 1'b0, '0};
    opening_rows[4]  = '{FUNC_DATA,  CH_ZERO,  1'b0, '0};
    opening_rows[5]  = '{FUNC_DATA,  CH_LF,    1'b1, outcome(0, 0, 0, 0, 0, 0, 0, 0)};
    opening_rows[6]  = '{FUNC_DATA,  8'h00,    1'b1, outcome(1, 0, 0, 0, 0, 0, 0, 0)};
    for (i = 7; i < 16; i++) opening_rows[i] = '{FUNC_DATA, CH_NINE, 1'b0, '0};
    opening_rows[16] = '{FUNC_DATA,  CH_NINE,  1'b1, outcome(0, 0, 0, 0, 0, 0, 0, 999999999)};
    opening_rows[17] = '{FUNC_DATA,  8'h78,    1'b1, outcome(0, 0, 0, 0, 0, 0, 0, 0)};
    opening_rows[18] = '{FUNC_START, 8'hFF,    1'b1, outcome(0, 0, 0, 0, 0, 0, 1, 0)};
    opening_rows[19] = '{FUNC_DATA,  8'h31,    1'b0, '0};
    opening_rows[20] = '{FUNC_DATA,  CH_LF,    1'b0, '0};
    opening_rows[21] = '{FUNC_DATA,  8'hA5,    1'b1, outcome(0, 1, 8'hA5, 1, 1, 1, 0, 1)};
    opening_rows[22] = '{FUNC_DATA,  8'h5A,    1'b1, outcome(0, 0, 0, 0, 1, 1, 0, 1)};
    opening_rows[23] = '{FUNC_TICK,  8'h00,    1'b0, '0};
    opening_rows[24] = '{FUNC_STOP,  8'h00,    1'b0, '0};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < OPENING_ROWS; i++)
      push_item(opening_rows[i].func, opening_rows[i].data, opening_rows[i].known,
                opening_rows[i].want);

    // Default timeout of 300 seconds
    run_random(300);

    // Zero timeout: a single tick drops the session
    retune(16'd0);
    run_random(250);

    // Longest timeout
    retune(16'hFFFF);
    idle_on = 1'b1;
    run_random(200);

    retune(16'd4);
    run_random(250);

    retune(16'($urandom_range(1, 20)));
    run_random(250);

    // Last stretch runs flat out with no gaps or stalls
    retune(16'd2);
    allow_idle = 1'b0;
    idle_on    = 1'b0;
    run_random(300);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("decimal_length_prefixed_deframer regression: pass");
    end else begin
      $display("decimal_length_prefixed_deframer regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #40_000_000;
    $display("decimal_length_prefixed_deframer regression: fail");
    $finish;
  end

endmodule
